// ===== hdl/gsac_pkg.sv =====
package gsac_pkg;

    localparam int ADC_W   = 10;
    localparam int CHAN_W  = 3;
    localparam int DUTY_W  = 16;
    localparam int CNT_W   = 16;
    localparam int DZ_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    // signed width for band edges around the middle position
    localparam int BAND_W  = 13;

    typedef logic [ADC_W-1:0]  adc_t;
    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [DZ_W-1:0]   dz_t;
    typedef logic [1:0]        motor_t;
    typedef logic signed [BAND_W-1:0] band_t;

    localparam motor_t MOTOR_STOP = 2'd0;
    localparam motor_t MOTOR_IN   = 2'd1;
    localparam motor_t MOTOR_OUT  = 2'd2;

    localparam logic FUNC_ADC  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] BTN_UP   = 2'd1;
    localparam logic [1:0] BTN_DOWN = 2'd2;

    localparam chan_t CHAN_CURRENT  = 3'd0;
    localparam chan_t CHAN_POSITION = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIDDLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IGN_MARGIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_CRIT = 3'd7;

    localparam adc_t RST_POS_MAX      = 10'd900;
    localparam adc_t RST_POS_MIN      = 10'd100;
    localparam adc_t RST_NEUTRAL_MAX  = 10'd700;
    localparam adc_t RST_NEUTRAL_MIN  = 10'd300;
    localparam adc_t RST_POS_MIDDLE   = 10'd512;
    localparam dz_t  RST_DEAD_ZONE    = 9'd20;
    localparam dz_t  RST_IGN_MARGIN   = 9'd30;
    localparam adc_t RST_CURRENT_CRIT = 10'd800;

    localparam adc_t ADC_FULL_SCALE = 10'd1023;
    localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

endpackage

// ===== hdl/gsac_lowpass.sv =====
module gsac_lowpass
    import gsac_pkg::*;
#(
    parameter int Q = 128
) (
    input  adc_t x,
    input  adc_t old,
    output adc_t y
);

    localparam int PROD_W = 19;
    localparam logic [8:0] QW = 9'(Q);
    localparam logic [8:0] QI = 9'(256 - Q);

    logic [PROD_W-1:0] acc;

    // new = (q * x + (256 - q) * old) >> 8, truncated to 10 bits
    assign acc = PROD_W'(QW * x) + PROD_W'(QI * old);
    assign y   = acc[ADC_W+7:8];

endmodule

// ===== hdl/gear_shift_actuator_control_core.sv =====
// channel | ports                     | direction | accepted when
// input   | s_valid/s_ready, s_*      | in        | s_valid && s_ready
// result  | m_valid/m_ready, m_*      | out       | m_valid && m_ready
// config  | cfg_we, cfg_index, cfg_data | in      | cfg_we
//
// one word in, one word out; the result is registered on accept
// a new word is taken every cycle while the result register drains (s_ready
// follows m_ready when a result is held), so the rate is one word per cycle
// the filters and tick logic are combinational, ahead of the result register
// aresetn is synchronous, active low: state, config and m_valid go to reset values
module gear_shift_actuator_control_core
    import gsac_pkg::*;
#(
    parameter int OC_WARN_TICKS     = 20,
    parameter int OC_TRIP_TICKS     = 60,
    parameter int DUTY_MAX          = 1023,
    parameter int SCAN_CHANNELS     = 2,
    parameter int POS_FILTER_Q8     = 128,
    parameter int CURRENT_FILTER_Q8 = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  chan_t                 s_adc_channel,
    input  adc_t                  s_adc_sample,
    input  logic [1:0]            s_button,
    input  logic                  s_neutral_sensor,

    output logic                  m_valid,
    input  logic                  m_ready,
    output motor_t                m_motor_dir,
    output logic [DUTY_W-1:0]     m_motor_duty,
    output logic                  m_ign_cut,
    output logic                  m_bridge_enable,
    output logic                  m_shift_busy,
    output logic                  m_overcurrent_warn,
    output chan_t                 m_next_channel,
    output adc_t                  m_position
);

    localparam logic [CNT_W-1:0]  WARN_TICKS = CNT_W'(OC_WARN_TICKS);
    localparam logic [CNT_W-1:0]  TRIP_TICKS = CNT_W'(OC_TRIP_TICKS);
    localparam logic [DUTY_W-1:0] DUTY_RST   = DUTY_W'(DUTY_MAX);
    localparam logic [CHAN_W:0]   SCAN_N     = (CHAN_W+1)'(SCAN_CHANNELS);

    // configuration
    adc_t cfg_pos_max_reg, cfg_pos_min_reg, cfg_neu_max_reg, cfg_neu_min_reg;
    adc_t cfg_middle_reg, cfg_crit_reg;
    dz_t  cfg_dz_reg, cfg_ign_reg;

    // state
    adc_t              fpos_reg, fpos_next;
    adc_t              fcur_reg, fcur_next;
    chan_t             scan_reg, scan_next;
    logic              shift_reg, shift_next;
    logic              ret_max_reg, ret_max_next;
    logic              ret_min_reg, ret_min_next;
    adc_t              tmax_reg, tmax_next;
    adc_t              tmin_reg, tmin_next;
    logic [CNT_W-1:0]  oc_reg, oc_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    motor_t            motor_reg, motor_next;
    logic              bridge_reg, bridge_next;
    logic              ign_reg, ign_next;
    logic              warn_next;
    chan_t             chan_next;

    logic              m_valid_reg;
    motor_t            o_dir_reg;
    logic [DUTY_W-1:0] o_duty_reg;
    logic              o_ign_reg, o_bridge_reg, o_busy_reg, o_warn_reg;
    chan_t             o_chan_reg;
    adc_t              o_pos_reg;

    adc_t  cur_filt, pos_filt;
    logic [CHAN_W:0] scan_inc;
    band_t pos_s, mid_s, dz_s, ign_s;
    band_t dz_hi, dz_lo, ign_hi, ign_lo;
    logic  accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    gsac_lowpass #(.Q(CURRENT_FILTER_Q8)) u_cur_lp (
        .x   (s_adc_sample),
        .old (fcur_reg),
        .y   (cur_filt)
    );

    gsac_lowpass #(.Q(POS_FILTER_Q8)) u_pos_lp (
        .x   (ADC_FULL_SCALE - s_adc_sample),
        .old (fpos_reg),
        .y   (pos_filt)
    );

    assign scan_inc = {1'b0, scan_reg} + 1'b1;

    assign pos_s  = $signed({3'b000, fpos_reg});
    assign mid_s  = $signed({3'b000, cfg_middle_reg});
    assign dz_s   = $signed({4'b0000, cfg_dz_reg});
    assign ign_s  = $signed({4'b0000, cfg_ign_reg});
    assign dz_hi  = mid_s + dz_s;
    assign dz_lo  = mid_s - dz_s;
    assign ign_hi = dz_hi + ign_s;
    assign ign_lo = dz_lo - ign_s;

    always_comb begin
        fpos_next    = fpos_reg;
        fcur_next    = fcur_reg;
        scan_next    = scan_reg;
        shift_next   = shift_reg;
        ret_max_next = ret_max_reg;
        ret_min_next = ret_min_reg;
        tmax_next    = tmax_reg;
        tmin_next    = tmin_reg;
        oc_next      = oc_reg;
        duty_next    = duty_reg;
        motor_next   = motor_reg;
        bridge_next  = bridge_reg;
        ign_next     = ign_reg;
        warn_next    = 1'b0;
        chan_next    = scan_reg;

        if (s_func == FUNC_ADC) begin
            if (s_adc_channel == CHAN_CURRENT) begin
                fcur_next = cur_filt;
            end else if (s_adc_channel == CHAN_POSITION) begin
                fpos_next = pos_filt;
            end
        end else begin
            scan_next = (scan_inc >= SCAN_N) ? '0 : scan_inc[CHAN_W-1:0];

            if ((s_button == BTN_UP || s_button == BTN_DOWN) && !shift_reg &&
                !ret_max_reg && !ret_min_reg) begin
                shift_next = 1'b1;
                motor_next = (s_button == BTN_UP) ? MOTOR_IN : MOTOR_OUT;
                if (s_neutral_sensor) begin
                    tmax_next = cfg_neu_max_reg;
                    tmin_next = cfg_neu_min_reg;
                end else begin
                    tmax_next = cfg_pos_max_reg;
                    tmin_next = cfg_pos_min_reg;
                end
            end

            ign_next = (pos_s > ign_hi) || (pos_s < ign_lo);

            // limit check uses the targets just chosen
            if (!ret_max_reg && !ret_min_reg) begin
                if (fpos_reg > tmax_next) begin
                    motor_next   = MOTOR_STOP;
                    ret_max_next = 1'b1;
                end else if (fpos_reg < tmin_next) begin
                    motor_next   = MOTOR_STOP;
                    ret_min_next = 1'b1;
                end
            end

            if (fcur_reg > cfg_crit_reg) begin
                if (oc_reg != CNT_SAT) begin
                    oc_next = oc_reg + 1'b1;
                end
            end else if (oc_reg != '0) begin
                oc_next = oc_reg - 1'b1;
            end

            warn_next = oc_next > WARN_TICKS;
            if (warn_next && pos_s > dz_hi) begin
                ret_min_next = 1'b0;
                ret_max_next = 1'b1;
            end
            if (warn_next && pos_s < dz_lo) begin
                ret_min_next = 1'b1;
                ret_max_next = 1'b0;
            end
            // trip latches until reset
            if (oc_next > TRIP_TICKS) begin
                duty_next   = '0;
                bridge_next = 1'b0;
            end

            if (ret_max_next) begin
                if (pos_s > dz_hi) begin
                    motor_next = MOTOR_IN;
                end else begin
                    motor_next   = MOTOR_STOP;
                    ret_max_next = 1'b0;
                    ret_min_next = 1'b0;
                    shift_next   = 1'b0;
                end
            end
            if (ret_min_next) begin
                if (pos_s < dz_lo) begin
                    motor_next = MOTOR_OUT;
                end else begin
                    motor_next   = MOTOR_STOP;
                    ret_max_next = 1'b0;
                    ret_min_next = 1'b0;
                    shift_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pos_max_reg <= RST_POS_MAX;
            cfg_pos_min_reg <= RST_POS_MIN;
            cfg_neu_max_reg <= RST_NEUTRAL_MAX;
            cfg_neu_min_reg <= RST_NEUTRAL_MIN;
            cfg_middle_reg  <= RST_POS_MIDDLE;
            cfg_dz_reg      <= RST_DEAD_ZONE;
            cfg_ign_reg     <= RST_IGN_MARGIN;
            cfg_crit_reg    <= RST_CURRENT_CRIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POS_MAX:      cfg_pos_max_reg <= cfg_data;
                CFG_POS_MIN:      cfg_pos_min_reg <= cfg_data;
                CFG_NEUTRAL_MAX:  cfg_neu_max_reg <= cfg_data;
                CFG_NEUTRAL_MIN:  cfg_neu_min_reg <= cfg_data;
                CFG_POS_MIDDLE:   cfg_middle_reg  <= cfg_data;
                CFG_DEAD_ZONE:    cfg_dz_reg      <= cfg_data[DZ_W-1:0];
                CFG_IGN_MARGIN:   cfg_ign_reg     <= cfg_data[DZ_W-1:0];
                CFG_CURRENT_CRIT: cfg_crit_reg    <= cfg_data;
                default:          cfg_crit_reg    <= cfg_crit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpos_reg    <= '0;
            fcur_reg    <= '0;
            scan_reg    <= '0;
            shift_reg   <= 1'b0;
            ret_max_reg <= 1'b0;
            ret_min_reg <= 1'b0;
            tmax_reg    <= RST_POS_MAX;
            tmin_reg    <= RST_POS_MIN;
            oc_reg      <= '0;
            duty_reg    <= DUTY_RST;
            motor_reg   <= MOTOR_STOP;
            bridge_reg  <= 1'b1;
            ign_reg     <= 1'b0;
        end else if (accept) begin
            fpos_reg    <= fpos_next;
            fcur_reg    <= fcur_next;
            scan_reg    <= scan_next;
            shift_reg   <= shift_next;
            ret_max_reg <= ret_max_next;
            ret_min_reg <= ret_min_next;
            tmax_reg    <= tmax_next;
            tmin_reg    <= tmin_next;
            oc_reg      <= oc_next;
            duty_reg    <= duty_next;
            motor_reg   <= motor_next;
            bridge_reg  <= bridge_next;
            ign_reg     <= ign_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result word, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            o_dir_reg    <= motor_next;
            o_duty_reg   <= (motor_next == MOTOR_STOP) ? '0 : duty_next;
            o_ign_reg    <= ign_next;
            o_bridge_reg <= bridge_next;
            o_busy_reg   <= shift_next || ret_max_next || ret_min_next;
            o_warn_reg   <= warn_next;
            o_chan_reg   <= chan_next;
            o_pos_reg    <= fpos_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_motor_dir        = o_dir_reg;
    assign m_motor_duty       = o_duty_reg;
    assign m_ign_cut          = o_ign_reg;
    assign m_bridge_enable    = o_bridge_reg;
    assign m_shift_busy       = o_busy_reg;
    assign m_overcurrent_warn = o_warn_reg;
    assign m_next_channel     = o_chan_reg;
    assign m_position         = o_pos_reg;

endmodule
